### rtl/acked_command_frame_sender_assert.svh
// assertion macros shared by the acked command frame sender modules
`ifndef ACKED_COMMAND_FRAME_SENDER_ASSERT_SVH
`define ACKED_COMMAND_FRAME_SENDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ACFS_AST_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acfs assertion failed");

// next-cycle implication, checked out of reset
`define ACFS_AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acfs assertion failed");

`endif

### rtl/acfs_pkg.sv
// package: sizes, codes and control structs of the acked command frame sender
package acfs_pkg;

    localparam int OBJ_SLOTS   = 8;
    localparam int STR_SLOTS   = 4;
    localparam int MAX_STR_LEN = 32;

    localparam int OBJ_IW     = (OBJ_SLOTS > 1) ? $clog2(OBJ_SLOTS) : 1;
    localparam int STR_IW     = (STR_SLOTS > 1) ? $clog2(STR_SLOTS) : 1;
    localparam int LEN_W      = $clog2(MAX_STR_LEN + 1);
    localparam int CHAR_DEPTH = STR_SLOTS * MAX_STR_LEN;
    localparam int CHAR_AW    = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1;
    localparam int FRAME_MAX  = (MAX_STR_LEN + 3 > 6) ? MAX_STR_LEN + 3 : 6;
    localparam int CNT_W      = $clog2(FRAME_MAX);

    // action codes
    localparam logic [1:0] ACT_OBJ     = 2'd0;
    localparam logic [1:0] ACT_CHR     = 2'd1;
    localparam logic [1:0] ACT_POLL    = 2'd2;
    localparam logic [1:0] ACT_RESTART = 2'd3;

    // register map
    localparam int          ADDR_W    = 5;
    localparam logic [2:0]  REG_DELAY = 3'd0;
    localparam logic [2:0]  REG_ACK   = 3'd1;
    localparam logic [2:0]  REG_NAK   = 3'd2;
    localparam logic [2:0]  REG_OBJOP = 3'd3;
    localparam logic [2:0]  REG_STROP = 3'd4;

    // frame byte positions
    localparam logic [CNT_W-1:0] POS_OPCODE = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_HEAD   = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_BODY   = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_VALHI  = CNT_W'(3);
    localparam logic [CNT_W-1:0] OBJ_LAST   = CNT_W'(5);

    typedef struct packed {
        logic [15:0] delay;
        logic [7:0]  ack;
        logic [7:0]  nak;
        logic [7:0]  obj_op;
        logic [7:0]  str_op;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
        logic put_byte;
        logic put_single;
    } cmd_t;

    typedef struct packed {
        logic will_send;
        logic out_free;
        logic frame_end;
    } status_t;

endpackage

### rtl/acfs_ram.sv
// generic single-write, single-read ram with registered read data
module acfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/acfs_regs.sv
// configuration register file behind the apb-style port
module acfs_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acfs_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output acfs_pkg::cfg_t                cfg
);
    import acfs_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_DELAY: cfg_next.delay  = pwdata[15:0];
                REG_ACK:   cfg_next.ack    = pwdata[7:0];
                REG_NAK:   cfg_next.nak    = pwdata[7:0];
                REG_OBJOP: cfg_next.obj_op = pwdata[7:0];
                REG_STROP: cfg_next.str_op = pwdata[7:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DELAY: prdata = {16'd0, cfg_reg.delay};
            REG_ACK:   prdata = {24'd0, cfg_reg.ack};
            REG_NAK:   prdata = {24'd0, cfg_reg.nak};
            REG_OBJOP: prdata = {24'd0, cfg_reg.obj_op};
            REG_STROP: prdata = {24'd0, cfg_reg.str_op};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay  <= 16'd1000;
            cfg_reg.ack    <= 8'd6;
            cfg_reg.nak    <= 8'd21;
            cfg_reg.obj_op <= 8'd1;
            cfg_reg.str_op <= 8'd2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/acfs_dp.sv
// datapath: slot stores, string memory, poll logic, frame builder, output register
module acfs_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  acfs_pkg::cmd_t      cmd,
    output acfs_pkg::status_t   status,
    input  acfs_pkg::cfg_t      cfg,
    input  logic [1:0]          action,
    input  logic [7:0]          obj_id,
    input  logic [7:0]          obj_index,
    input  logic [15:0]         obj_value,
    input  logic [7:0]          str_index,
    input  logic [7:0]          str_char,
    input  logic                str_end,
    input  logic                rx_valid,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                tx_valid,
    output logic [7:0]          tx_byte,
    output logic                run_last,
    output logic                accepted,
    output logic                enabled,
    output logic                ack_pending
);
    import acfs_pkg::*;

    // captured transaction
    logic [1:0]  act_reg, act_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  idx_reg, idx_next;
    logic [15:0] val_reg, val_next;
    logic [7:0]  sidx_reg, sidx_next;
    logic [7:0]  char_reg, char_next;
    logic        send_reg, send_next;
    logic        rxv_reg, rxv_next;
    logic [7:0]  rxb_reg, rxb_next;

    // slot stores
    logic [OBJ_SLOTS-1:0] obj_valid_reg, obj_valid_next;
    logic [31:0]          obj_data_reg [OBJ_SLOTS];
    logic [31:0]          obj_data_next [OBJ_SLOTS];
    logic [STR_SLOTS-1:0] str_valid_reg, str_valid_next;
    logic [7:0]           str_idx_reg [STR_SLOTS];
    logic [7:0]           str_idx_next [STR_SLOTS];
    logic [LEN_W-1:0]     str_len_reg [STR_SLOTS];
    logic [LEN_W-1:0]     str_len_next [STR_SLOTS];

    // open string
    logic              fill_open_reg, fill_open_next;
    logic [STR_IW-1:0] fill_slot_reg, fill_slot_next;
    logic [LEN_W-1:0]  fill_len_reg, fill_len_next;

    // send control
    logic        enabled_reg, enabled_next;
    logic        waiting_reg, waiting_next;
    logic [15:0] ticks_reg, ticks_next;
    logic        acc_reg, acc_next;

    // frame in flight
    logic              frm_obj_reg, frm_obj_next;
    logic [31:0]       frm_data_reg, frm_data_next;
    logic [STR_IW-1:0] frm_slot_reg, frm_slot_next;
    logic [CNT_W-1:0]  frm_last_reg, frm_last_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        xor_reg, xor_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       tx_valid_reg, tx_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       run_last_reg, run_last_next;
    logic       accepted_reg, accepted_next;
    logic       enabled_o_reg, enabled_o_next;
    logic       ack_o_reg, ack_o_next;

    // lookups
    logic              obj_free_found, obj_any;
    logic [OBJ_IW-1:0] obj_free_idx, obj_sel;
    logic              str_free_found, str_any;
    logic [STR_IW-1:0] str_free_idx, str_sel;
    logic              chr_open;
    logic [STR_IW-1:0] chr_slot;
    logic [LEN_W-1:0]  chr_len;
    logic [15:0]       poll_ticks;
    logic              en_set, poll_en, poll_wait, rx_hit, will_send;
    logic              is_char;
    logic [CNT_W-1:0]  char_pos;
    logic [7:0]        frame_byte;

    // char memory
    logic               ram_we, ram_re;
    logic [CHAR_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]         ram_rdata;

    acfs_ram #(
        .WIDTH (8),
        .DEPTH (CHAR_DEPTH)
    ) u_char_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (char_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // lowest free / lowest queued slot
    always_comb
    begin
        obj_free_found = 1'b0;
        obj_free_idx   = '0;
        obj_any        = 1'b0;
        obj_sel        = '0;
        for (int i = OBJ_SLOTS - 1; i >= 0; i--)
        begin
            if (!obj_valid_reg[i])
            begin
                obj_free_found = 1'b1;
                obj_free_idx   = OBJ_IW'(i);
            end
            if (obj_valid_reg[i])
            begin
                obj_any = 1'b1;
                obj_sel = OBJ_IW'(i);
            end
        end
    end

    always_comb
    begin
        str_free_found = 1'b0;
        str_free_idx   = '0;
        str_any        = 1'b0;
        str_sel        = '0;
        for (int i = STR_SLOTS - 1; i >= 0; i--)
        begin
            if (!str_valid_reg[i])
            begin
                str_free_found = 1'b1;
                str_free_idx   = STR_IW'(i);
            end
            if (str_valid_reg[i])
            begin
                str_any = 1'b1;
                str_sel = STR_IW'(i);
            end
        end
    end

    assign chr_open = fill_open_reg || str_free_found;
    assign chr_slot = fill_open_reg ? fill_slot_reg : str_free_idx;
    assign chr_len  = fill_open_reg ? fill_len_reg : '0;

    // poll tick: counter, enable, ack/nak
    assign poll_ticks = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
    assign en_set     = !enabled_reg && (poll_ticks > cfg.delay);
    assign poll_en    = enabled_reg || en_set;
    assign rx_hit     = rxv_reg && ((rxb_reg == cfg.ack) || (rxb_reg == cfg.nak));
    assign poll_wait  = waiting_reg && !en_set && !rx_hit;
    assign will_send  = (act_reg == ACT_POLL) && poll_en && !poll_wait && (obj_any || str_any);

    // frame byte selection
    assign is_char  = !frm_obj_reg && (cnt_reg >= POS_BODY) && (cnt_reg != frm_last_reg);
    assign char_pos = cnt_reg - POS_BODY;

    always_comb
    begin
        priority if (cnt_reg == frm_last_reg)
        begin
            frame_byte = xor_reg;
        end
        else if (cnt_reg == POS_OPCODE)
        begin
            frame_byte = frm_obj_reg ? cfg.obj_op : cfg.str_op;
        end
        else if (cnt_reg == POS_HEAD)
        begin
            frame_byte = frm_data_reg[31:24];
        end
        else if (!frm_obj_reg)
        begin
            frame_byte = ram_rdata;
        end
        else if (cnt_reg == POS_BODY)
        begin
            frame_byte = frm_data_reg[23:16];
        end
        else if (cnt_reg == POS_VALHI)
        begin
            frame_byte = frm_data_reg[15:8];
        end
        else
        begin
            frame_byte = frm_data_reg[7:0];
        end
    end

    always_comb
    begin
        act_next  = act_reg;
        id_next   = id_reg;
        idx_next  = idx_reg;
        val_next  = val_reg;
        sidx_next = sidx_reg;
        char_next = char_reg;
        send_next = send_reg;
        rxv_next  = rxv_reg;
        rxb_next  = rxb_reg;

        obj_valid_next = obj_valid_reg;
        obj_data_next  = obj_data_reg;
        str_valid_next = str_valid_reg;
        str_idx_next   = str_idx_reg;
        str_len_next   = str_len_reg;
        fill_open_next = fill_open_reg;
        fill_slot_next = fill_slot_reg;
        fill_len_next  = fill_len_reg;
        enabled_next   = enabled_reg;
        waiting_next   = waiting_reg;
        ticks_next     = ticks_reg;
        acc_next       = acc_reg;

        frm_obj_next  = frm_obj_reg;
        frm_data_next = frm_data_reg;
        frm_slot_next = frm_slot_reg;
        frm_last_next = frm_last_reg;
        cnt_next      = cnt_reg;
        xor_next      = xor_reg;

        out_valid_next = out_valid_reg && !out_ready;
        tx_valid_next  = tx_valid_reg;
        tx_byte_next   = tx_byte_reg;
        run_last_next  = run_last_reg;
        accepted_next  = accepted_reg;
        enabled_o_next = enabled_o_reg;
        ack_o_next     = ack_o_reg;

        ram_we    = 1'b0;
        ram_waddr = CHAR_AW'(CHAR_AW'(chr_slot) * CHAR_AW'(MAX_STR_LEN) + CHAR_AW'(chr_len));
        ram_re    = 1'b0;
        ram_raddr = CHAR_AW'(CHAR_AW'(frm_slot_reg) * CHAR_AW'(MAX_STR_LEN)
                             + CHAR_AW'(char_pos));

        if (cmd.capture)
        begin
            act_next  = action;
            id_next   = obj_id;
            idx_next  = obj_index;
            val_next  = obj_value;
            sidx_next = str_index;
            char_next = str_char;
            send_next = str_end;
            rxv_next  = rx_valid;
            rxb_next  = rx_byte;
        end

        if (cmd.exec)
        begin
            acc_next = 1'b0;
            unique case (act_reg)
                ACT_OBJ:
                begin
                    if (obj_free_found)
                    begin
                        obj_valid_next[obj_free_idx] = 1'b1;
                        obj_data_next[obj_free_idx]  = {id_reg, idx_reg, val_reg};
                        acc_next = 1'b1;
                    end
                end
                ACT_CHR:
                begin
                    if (chr_open)
                    begin
                        if (!fill_open_reg)
                        begin
                            str_idx_next[chr_slot] = sidx_reg;
                        end
                        if (chr_len < LEN_W'(MAX_STR_LEN))
                        begin
                            ram_we        = 1'b1;
                            fill_len_next = chr_len + LEN_W'(1);
                            acc_next      = 1'b1;
                        end
                        else
                        begin
                            fill_len_next = chr_len;
                        end
                        fill_slot_next = chr_slot;
                        if (send_reg)
                        begin
                            str_valid_next[chr_slot] = 1'b1;
                            str_len_next[chr_slot]   = fill_len_next;
                            fill_open_next = 1'b0;
                        end
                        else
                        begin
                            fill_open_next = 1'b1;
                        end
                    end
                end
                ACT_POLL:
                begin
                    ticks_next   = poll_ticks;
                    enabled_next = poll_en;
                    waiting_next = poll_wait;
                    if (will_send)
                    begin
                        waiting_next = 1'b1;
                        cnt_next     = '0;
                        xor_next     = 8'd0;
                        if (obj_any)
                        begin
                            frm_obj_next            = 1'b1;
                            frm_data_next           = obj_data_reg[obj_sel];
                            frm_last_next           = OBJ_LAST;
                            obj_valid_next[obj_sel] = 1'b0;
                        end
                        else
                        begin
                            frm_obj_next            = 1'b0;
                            frm_data_next           = {str_idx_reg[str_sel], 24'd0};
                            frm_slot_next           = str_sel;
                            frm_last_next           = CNT_W'(str_len_reg[str_sel]) + POS_BODY;
                            str_valid_next[str_sel] = 1'b0;
                        end
                    end
                end
                ACT_RESTART:
                begin
                    obj_valid_next = '0;
                    str_valid_next = '0;
                    fill_open_next = 1'b0;
                    fill_slot_next = '0;
                    enabled_next   = 1'b0;
                    ticks_next     = 16'd0;
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end

        if (cmd.fetch)
        begin
            ram_re = is_char;
        end

        if (cmd.put_byte)
        begin
            out_valid_next = 1'b1;
            tx_valid_next  = 1'b1;
            tx_byte_next   = frame_byte;
            run_last_next  = (cnt_reg == frm_last_reg);
            accepted_next  = 1'b0;
            enabled_o_next = enabled_reg;
            ack_o_next     = waiting_reg;
            xor_next       = xor_reg ^ frame_byte;
            cnt_next       = cnt_reg + CNT_W'(1);
        end

        if (cmd.put_single)
        begin
            out_valid_next = 1'b1;
            tx_valid_next  = 1'b0;
            tx_byte_next   = 8'd0;
            run_last_next  = 1'b1;
            accepted_next  = acc_reg;
            enabled_o_next = enabled_reg;
            ack_o_next     = waiting_reg;
        end
    end

    assign status.will_send = will_send;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.frame_end = (cnt_reg == frm_last_reg);

    assign out_valid   = out_valid_reg;
    assign tx_valid    = tx_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign run_last    = run_last_reg;
    assign accepted    = accepted_reg;
    assign enabled     = enabled_o_reg;
    assign ack_pending = ack_o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_valid_reg <= '0;
            str_valid_reg <= '0;
            fill_open_reg <= 1'b0;
            enabled_reg   <= 1'b0;
            waiting_reg   <= 1'b0;
            ticks_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            obj_valid_reg <= obj_valid_next;
            str_valid_reg <= str_valid_next;
            fill_open_reg <= fill_open_next;
            enabled_reg   <= enabled_next;
            waiting_reg   <= waiting_next;
            ticks_reg     <= ticks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        id_reg   <= id_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        sidx_reg <= sidx_next;
        char_reg <= char_next;
        send_reg <= send_next;
        rxv_reg  <= rxv_next;
        rxb_reg  <= rxb_next;

        obj_data_reg   <= obj_data_next;
        str_idx_reg    <= str_idx_next;
        str_len_reg    <= str_len_next;
        fill_slot_reg  <= fill_slot_next;
        fill_len_reg   <= fill_len_next;
        acc_reg        <= acc_next;

        frm_obj_reg  <= frm_obj_next;
        frm_data_reg <= frm_data_next;
        frm_slot_reg <= frm_slot_next;
        frm_last_reg <= frm_last_next;
        cnt_reg      <= cnt_next;
        xor_reg      <= xor_next;

        tx_valid_reg  <= tx_valid_next;
        tx_byte_reg   <= tx_byte_next;
        run_last_reg  <= run_last_next;
        accepted_reg  <= accepted_next;
        enabled_o_reg <= enabled_o_next;
        ack_o_reg     <= ack_o_next;
    end

`include "acked_command_frame_sender_assert.svh"

    // a frame byte only goes out while the frame waits for its ack
    `ACFS_AST_IMPL(a_frame_sets_waiting, cmd.put_byte, waiting_reg)
    // the checksum byte cancels the running xor of the frame
    `ACFS_AST_NEXT(a_checksum_closes, cmd.put_byte && status.frame_end, xor_reg == 8'd0)
    // a string being filled is never queued for sending
    `ACFS_AST_IMPL(a_open_not_queued, fill_open_reg, !str_valid_reg[fill_slot_reg])

endmodule

### rtl/acfs_ctrl.sv
// controller: sequences accept, execute, single result and frame byte steps
module acfs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  acfs_pkg::status_t   status,
    output acfs_pkg::cmd_t      cmd
);
    import acfs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_ONE   = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.will_send ? S_FETCH : S_ONE;
            end
            S_ONE:
            begin
                if (status.out_free)
                begin
                    cmd.put_single = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.put_byte = 1'b1;
                    state_next   = status.frame_end ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`include "acked_command_frame_sender_assert.svh"

    // every accepted transaction is executed in the following cycle
    `ACFS_AST_NEXT(a_exec_follows_accept, in_valid && in_ready, cmd.exec)
    // a waiting result blocks the next byte
    `ACFS_AST_IMPL(a_no_put_when_full, cmd.put_byte || cmd.put_single, status.out_free)
    // a frame byte is always preceded by its fetch step
    `ACFS_AST_IMPL(a_fetch_before_put, cmd.put_byte, $past(cmd.fetch) || $past(state_reg) == S_PUT)

endmodule

### rtl/acked_command_frame_sender.sv
// top level of the acked command frame sender
//
//  channel   dir  handshake            transaction
//  --------  ---  -------------------  ------------------------------------------
//  input     in   in_valid/in_ready    action with object, string and rx fields
//  output    out  out_valid/out_ready  tx_valid, tx_byte, run_last, accepted,
//                                      enabled, ack_pending
//  config    in   psel/penable/pwrite  apb-style register write, pready tied high
//
//  steps: an add, restart or poll without a frame passes accept, execute and
//  result load; after the execute step a frame sends each byte as a fetch
//  and a put step, the fetch covering the registered read of the string
//  character memory (6 bytes for an object, string length + 3 for a string)
//  reset: rst_n clears all slots, the open string, tick counter, enable and
//  pending flags; registers return to their defaults; no clearing pass
//  stalls: the output register holds a result until taken; the next byte or
//  result waits on it, and no new transaction is taken before the run is out
module acked_command_frame_sender (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [7:0]                    obj_id,
    input  logic [7:0]                    obj_index,
    input  logic [15:0]                   obj_value,
    input  logic [7:0]                    str_index,
    input  logic [7:0]                    str_char,
    input  logic                          str_end,
    input  logic                          rx_valid,
    input  logic [7:0]                    rx_byte,
    // output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          tx_valid,
    output logic [7:0]                    tx_byte,
    output logic                          run_last,
    output logic                          accepted,
    output logic                          enabled,
    output logic                          ack_pending,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acfs_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import acfs_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // register file: delay, ack/nak codes, frame opcodes
    acfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: one transaction at a time, one frame byte per fetch/put pair
    acfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // slots, string memory, poll handling and the output register
    acfs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg         (cfg),
        .action      (action),
        .obj_id      (obj_id),
        .obj_index   (obj_index),
        .obj_value   (obj_value),
        .str_index   (str_index),
        .str_char    (str_char),
        .str_end     (str_end),
        .rx_valid    (rx_valid),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .run_last    (run_last),
        .accepted    (accepted),
        .enabled     (enabled),
        .ack_pending (ack_pending)
    );

endmodule
